FILE: rtl/rmid_pkg.sv
package rmid_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_OUT_W = 9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [1:0] {
    DP_OP_NONE  = 2'd0,
    DP_OP_LOAD  = 2'd1,
    DP_OP_SHIFT = 2'd2,
    DP_OP_FINAL = 2'd3
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic shift_done;
    logic median_ready;
  } dp_stat_t;

endpackage

FILE: rtl/rmid_ram.sv
module rmid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rmid_datapath.sv
module rmid_datapath #(
  parameter int unsigned CAPACITY = rmid_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rmid_pkg::dp_cmd_t         cmd,
  output rmid_pkg::dp_stat_t        stat,
  input  logic                      in_action,
  input  logic signed [31:0]        in_value,
  output logic signed [31:0]        res_median,
  output logic [8:0]                res_lower,
  output logic [8:0]                res_upper,
  output logic [1:0]                res_status
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // search and shift share one ram read port; the ram read data is registered
  typedef enum logic [4:0] {
    PH_SRCH  = 5'b00001,
    PH_SWAIT = 5'b00010,
    PH_SHIFT = 5'b00100,
    PH_MED   = 5'b01000,
    PH_DONE  = 5'b10000
  } ph_t;

  ph_t            ph_r, ph_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]  mid_r, mid_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [31:0]    key_r, key_nxt;
  logic           act_r, act_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [31:0]    carry_r, carry_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic signed [31:0] med_r, med_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata;
  logic [CW-1:0]  lower_c;

  rmid_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign lower_c = CW'((({1'b0, cnt_r} + 1'b1) >> 1));

  always_comb begin
    ph_nxt = ph_r; cnt_nxt = cnt_r; lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r;
    idx_nxt = idx_r; key_nxt = key_r; act_nxt = act_r; st_nxt = st_r;
    carry_nxt = carry_r; rd_pend_nxt = 1'b0; med_nxt = med_r;
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = carry_r; raddr = mid_r[AW-1:0];
    stat = '0;
    unique case (cmd.op)
      rmid_pkg::DP_OP_LOAD: begin
        key_nxt = in_value ^ 32'h8000_0000;
        act_nxt = in_action;
        lo_nxt = '0; hi_nxt = cnt_r; st_nxt = rmid_pkg::ST_OK;
        ph_nxt = PH_SRCH;
      end
      rmid_pkg::DP_OP_SHIFT: begin
        unique case (ph_r)
          PH_SRCH: begin
            if (lo_r < hi_r) begin
              mid_nxt = lo_r + ((hi_r - lo_r) >> 1);
              raddr = mid_nxt[AW-1:0];
              ph_nxt = PH_SWAIT;
            end else begin
              idx_nxt = lo_r;
              if (act_r == rmid_pkg::ACT_INSERT) begin
                if (cnt_r >= CW'(CAPACITY)) begin
                  st_nxt = rmid_pkg::ST_FULL; ph_nxt = PH_MED;
                end else begin
                  carry_nxt = key_r;
                  raddr = lo_r[AW-1:0];
                  rd_pend_nxt = 1'b1;
                  ph_nxt = PH_SHIFT;
                end
              end else begin
                if (lo_r < cnt_r) begin
                  raddr = lo_r[AW-1:0];
                  rd_pend_nxt = 1'b1;
                  ph_nxt = PH_SHIFT;
                end else begin
                  st_nxt = rmid_pkg::ST_NOT_FOUND; ph_nxt = PH_MED;
                end
              end
            end
          end
          PH_SWAIT: begin
            if (rdata < key_r) lo_nxt = mid_r + 1'b1;
            else hi_nxt = mid_r;
            ph_nxt = PH_SRCH;
          end
          PH_SHIFT: begin
            if (act_r == rmid_pkg::ACT_INSERT) begin
              // ripple: write carry at idx, carry old entry onward
              if (rd_pend_r) begin
                we = 1'b1; waddr = idx_r[AW-1:0]; wdata = carry_r;
                if (idx_r >= cnt_r) begin
                  cnt_nxt = cnt_r + 1'b1; ph_nxt = PH_MED;
                end else begin
                  carry_nxt = rdata;
                  idx_nxt = idx_r + 1'b1;
                  raddr = idx_nxt[AW-1:0];
                  rd_pend_nxt = 1'b1;
                end
              end
            end else begin
              if (rd_pend_r) begin
                if (idx_r == lo_r && rdata != key_r) begin
                  st_nxt = rmid_pkg::ST_NOT_FOUND; ph_nxt = PH_MED;
                end else if (idx_r + 1'b1 >= cnt_r) begin
                  cnt_nxt = cnt_r - 1'b1; ph_nxt = PH_MED;
                end else begin
                  raddr = AW'(idx_r + 1'b1);
                  mid_nxt = idx_r;
                  idx_nxt = idx_r + 1'b1;
                  rd_pend_nxt = 1'b1;
                end
                if (idx_r != lo_r) begin
                  we = 1'b1; waddr = AW'(idx_r - 1'b1); wdata = rdata;
                end
              end
            end
          end
          PH_MED: begin
            raddr = AW'(lower_c - 1'b1);
            rd_pend_nxt = 1'b1;
            ph_nxt = PH_DONE;
          end
          PH_DONE: ;
          default: ;
        endcase
      end
      rmid_pkg::DP_OP_FINAL: begin
        if (cnt_r == '0) begin
          med_nxt = '0;
          if (st_r == rmid_pkg::ST_OK) st_nxt = rmid_pkg::ST_EMPTY;
        end else begin
          med_nxt = rdata ^ 32'h8000_0000;
        end
      end
      default: ;
    endcase
    stat.search_done = (ph_r == PH_DONE);
    stat.shift_done = (ph_r == PH_DONE);
    stat.median_ready = (ph_r == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_DONE;
      cnt_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      cnt_r <= cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt; idx_r <= idx_nxt;
    key_r <= key_nxt; act_r <= act_nxt; st_r <= st_nxt; carry_r <= carry_nxt;
    med_r <= med_nxt;
  end

  assign res_median = med_r;
  assign res_lower = 9'(lower_c);
  assign res_upper = 9'(cnt_r >> 1);
  assign res_status = st_r;

endmodule

FILE: rtl/rmid_ctrl.sv
module rmid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rmid_pkg::dp_cmd_t  cmd,
  input  rmid_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op = rmid_pkg::DP_OP_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = rmid_pkg::DP_OP_LOAD;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.op = rmid_pkg::DP_OP_SHIFT;
        if (stat.median_ready && stat.shift_done) begin
          cmd.op = rmid_pkg::DP_OP_FINAL;
          state_nxt = S_OUT;
        end
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: rtl/running_median_insert_delete.sv
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_action, in_value
// out     | output    | out_valid, out_ready, out_median, out_lower_count,
//         |           | out_upper_count, out_status
// an item passes through accept, search steps (at most ceil(log2(count+1))),
// each a ram read and a compare, search end, a shift step per entry moved,
// last shift, median read, final and result; a full insert or an absent delete
// may skip the last shift
// reset clears the element count; store contents need no clearing
// one item at a time; a stalled result holds the input side off
module running_median_insert_delete #(
  parameter int unsigned CAPACITY = rmid_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_median,
  output logic [8:0]         out_lower_count,
  output logic [8:0]         out_upper_count,
  output logic [1:0]         out_status
);

  rmid_pkg::dp_cmd_t  cmd;
  rmid_pkg::dp_stat_t stat;

  rmid_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  rmid_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_action(in_action), .in_value(in_value),
    .res_median(out_median), .res_lower(out_lower_count),
    .res_upper(out_upper_count), .res_status(out_status)
  );

endmodule

FILE: rtl/rmid_checker.sv
module rmid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  out_lower_count,
  input logic [8:0]  out_upper_count,
  input logic [1:0]  out_status
);

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lower_count == out_upper_count ||
                   out_lower_count == out_upper_count + 9'd1))
    else $error("halves unbalanced");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rmid_pkg::ST_EMPTY |-> out_lower_count == 9'd0)
    else $error("empty status with elements");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("accept while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");

endmodule

bind running_median_insert_delete rmid_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_lower_count(out_lower_count), .out_upper_count(out_upper_count),
  .out_status(out_status)
);

FILE: tb/running_median_insert_delete_tb.sv
`timescale 1ns / 1ps

module running_median_insert_delete_tb;

  localparam int unsigned CAP = rmid_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic signed [31:0] median;
    logic [8:0]         lower_count;
    logic [8:0]         upper_count;
    logic [1:0]         status;
  } median_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_median;
  logic [8:0]         out_lower_count;
  logic [8:0]         out_upper_count;
  logic [1:0]         out_status;

  int error_count;
  bit hold_off;
  bit stim_done;

  running_median_insert_delete u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_median(out_median),
    .out_lower_count(out_lower_count),
    .out_upper_count(out_upper_count),
    .out_status(out_status)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  class median_scoreboard;
    logic signed [31:0] sorted_vals[$];
    median_result_t     pending[$];

    function void note_transaction(input logic act, input logic signed [31:0] val);
      median_result_t r;
      int pos;
      int found;
      int n;
      r.status = rmid_pkg::ST_OK;
      pos = 0;
      found = -1;
      while (pos < sorted_vals.size() && sorted_vals[pos] < val) pos++;
      if (pos < sorted_vals.size() && sorted_vals[pos] == val) found = pos;
      if (act == rmid_pkg::ACT_INSERT) begin
        if (sorted_vals.size() >= CAP) r.status = rmid_pkg::ST_FULL;
        else sorted_vals.insert(pos, val);
      end else begin
        if (found >= 0) sorted_vals.delete(found);
        else r.status = rmid_pkg::ST_NOT_FOUND;
      end
      n = sorted_vals.size();
      r.lower_count = 9'((n + 1) / 2);
      r.upper_count = 9'(n / 2);
      if (n == 0) begin
        r.median = '0;
        if (r.status == rmid_pkg::ST_OK) r.status = rmid_pkg::ST_EMPTY;
      end else begin
        r.median = sorted_vals[(n + 1) / 2 - 1];
      end
      pending.push_back(r);
    endfunction

    task check_result(input median_result_t got);
      median_result_t exp;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp = pending.pop_front();
        if (got.median !== exp.median)
          report_mismatch($sformatf("median %0d exp %0d", got.median, exp.median));
        if (got.lower_count !== exp.lower_count)
          report_mismatch($sformatf("lower_count %0d exp %0d", got.lower_count,
                                    exp.lower_count));
        if (got.upper_count !== exp.upper_count)
          report_mismatch($sformatf("upper_count %0d exp %0d", got.upper_count,
                                    exp.upper_count));
        if (got.status !== exp.status)
          report_mismatch($sformatf("status %0d exp %0d", got.status, exp.status));
      end
    endtask
  endclass

  median_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_transaction(in_action, in_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_median, out_lower_count, out_upper_count, out_status});
  end

  // receiver stall pattern
  initial begin
    int ph;
    out_ready = 1'b0;
    ph = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      ph++;
      if (hold_off) out_ready <= 1'b0;
      else if ((ph / 300) % 3 == 0) out_ready <= 1'b1;
      else if ((ph % 7) < 2) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(input logic act, input logic signed [31:0] val);
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value(input int mode);
    logic signed [31:0] v;
    case (mode)
      0: v = $urandom_range(0, 15) - 8;
      1: v = (sb.sorted_vals.size() > 0) ?
             sb.sorted_vals[$urandom_range(0, sb.sorted_vals.size() - 1)] : 32'sd5;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int burst;
    int fill_target;
    logic act;
    sb = new();
    error_count = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = rmid_pkg::ACT_INSERT;
    in_value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, duplicates
    send_item(rmid_pkg::ACT_DELETE, 32'sd0);
    send_item(rmid_pkg::ACT_INSERT, 32'sh7fffffff);
    send_item(rmid_pkg::ACT_INSERT, 32'sh80000000);
    send_item(rmid_pkg::ACT_INSERT, 32'sd0);
    send_item(rmid_pkg::ACT_INSERT, -32'sd1);
    send_item(rmid_pkg::ACT_INSERT, 32'sd0);
    send_item(rmid_pkg::ACT_DELETE, 32'sd12345);
    send_item(rmid_pkg::ACT_DELETE, 32'sd0);
    send_item(rmid_pkg::ACT_DELETE, 32'sh80000000);
    send_item(rmid_pkg::ACT_DELETE, 32'sh7fffffff);
    send_item(rmid_pkg::ACT_DELETE, -32'sd1);
    send_item(rmid_pkg::ACT_DELETE, 32'sd0);
    send_item(rmid_pkg::ACT_DELETE, 32'sd0);
    send_item(rmid_pkg::ACT_INSERT, 32'sh55555555);
    send_item(rmid_pkg::ACT_INSERT, 32'shaaaaaaaa);
    idle_gap(3);

    // long receiver hold-off while sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (12) send_item(rmid_pkg::ACT_INSERT, pick_value(2));
      end
    join

    // fill to capacity and beyond, then delete six and insert four
    while (sb.sorted_vals.size() + 4 < CAP)
      send_item(rmid_pkg::ACT_INSERT, pick_value($urandom_range(0, 2)));
    repeat (8) send_item(rmid_pkg::ACT_INSERT, pick_value($urandom_range(0, 2)));
    repeat (6) send_item(rmid_pkg::ACT_DELETE, pick_value(1));
    repeat (4) send_item(rmid_pkg::ACT_INSERT, pick_value(0));

    // random bursts
    for (int i = 0; i < 1100;) begin
      burst = $urandom_range(1, 20);
      fill_target = (i / 350) % 2;
      repeat (burst) begin
        if (fill_target == 0)
          act = ($urandom_range(0, 9) < 4) ? rmid_pkg::ACT_DELETE : rmid_pkg::ACT_INSERT;
        else
          act = ($urandom_range(0, 9) < 6) ? rmid_pkg::ACT_DELETE : rmid_pkg::ACT_INSERT;
        if (act == rmid_pkg::ACT_DELETE)
          send_item(act, pick_value(($urandom_range(0, 4) == 0) ? 2 : 1));
        else
          send_item(act, pick_value($urandom_range(0, 2)));
        i++;
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rmid_pkg.sv
rtl/rmid_ram.sv
rtl/rmid_datapath.sv
rtl/rmid_ctrl.sv
rtl/running_median_insert_delete.sv
rtl/rmid_checker.sv
tb/running_median_insert_delete_tb.sv
